// File: src/rlsu_pkg.sv
// shared types and codes of the load/store unit
`default_nettype none
package rlsu_pkg;

	typedef enum logic [2:0] {
		MODE_LB  = 3'd0,
		MODE_LH  = 3'd1,
		MODE_LW  = 3'd2,
		MODE_LBU = 3'd3,
		MODE_LHU = 3'd4,
		MODE_SB  = 3'd5,
		MODE_SH  = 3'd6,
		MODE_SW  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_RANGE      = 2'd2
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [31:0]        base_address;
		logic signed [11:0] offset;
		logic [31:0]        store_data;
	} req_t;

	typedef struct packed {
		logic [31:0] load_data;
		status_t     status;
	} rsp_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_ACCESS,
		FSM_LOAD
	} fsm_state_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic issue;
		logic emit_direct;
		logic emit_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic load_ok;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: src/riscv_load_store_unit.sv
// top level of the rv32i load/store unit
// Requests come in on req (valid/ready) and carry mode, base address, offset
// and store data; each request gives exactly one response on rsp (valid/ready)
// with the extended load value and a status code.
// The data memory is one single-port ram of MEM_WORDS 32-bit words.
// For stores and flagged accesses the response register is loaded straight from
// the access step; loads go on through the load step, which takes the ram's
// registered read. A new request is taken only once the last one is through
// the controller's capture/access/load steps around the single ram port.
// The response sits in an output register; a new request is taken while a
// finished response still waits there. When the receiver stalls, the next
// request holds before its memory access until the response register frees.
// After reset the ram is cleared one word per cycle; while the clear runs,
// req_ready stays low.
`default_nettype none
module riscv_load_store_unit #(
	parameter int MEM_WORDS = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire rlsu_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output rlsu_pkg::rsp_t      rsp
);
	import rlsu_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rlsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rlsu_datapath #(
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: src/rlsu_ram.sv
// single-port ram with byte write enables and registered read
`default_nettype none
module rlsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [WIDTH/8-1:0]         we,
	input  wire logic [$clog2(DEPTH)-1:0]   addr,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic      [WIDTH-1:0]           rdata
);
	localparam int NB = WIDTH / 8;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < NB; b++) begin
				if (we[b]) begin
					mem_q[addr][b*8 +: 8] <= wdata[b*8 +: 8];
				end
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/rlsu_ctrl.sv
// controller state machine of the load/store unit
`default_nettype none
module rlsu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire rlsu_pkg::dp_stat_t   stat,
	output rlsu_pkg::ctrl_cmd_t       cmd
);
	import rlsu_pkg::*;

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (stat.clear_done) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (req_valid) state_d = FSM_ACCESS;
			end
			FSM_ACCESS: begin
				if (stat.out_free) begin
					state_d = stat.load_ok ? FSM_LOAD : FSM_IDLE;
				end
			end
			FSM_LOAD: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			FSM_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			FSM_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			FSM_ACCESS: begin
				// hold the memory op until the result register can take the result
				cmd.issue       = stat.out_free;
				cmd.emit_direct = stat.out_free & ~stat.load_ok;
			end
			FSM_LOAD: begin
				cmd.emit_load = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/rlsu_datapath.sv
// address, alignment check, memory and result register of the load/store unit
`default_nettype none
module rlsu_datapath #(
	parameter int MEM_WORDS = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rlsu_pkg::req_t       req,
	input  wire rlsu_pkg::ctrl_cmd_t  cmd,
	output rlsu_pkg::dp_stat_t        stat,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rlsu_pkg::rsp_t            rsp
);
	import rlsu_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) * 33'd4;
	localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

	// captured transaction
	logic [31:0] ea_q;
	mode_t       mode_q;
	logic [31:0] data_q;
	status_t     status_q;

	logic [AW-1:0] clr_cnt_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [31:0] ea;
	logic        misaligned;
	status_t     status;
	logic        is_store;
	logic        access_ok;

	logic          ram_en;
	logic [3:0]    ram_we;
	logic [3:0]    store_be;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   store_wdata;
	logic [31:0]   ram_rdata;
	logic [7:0]    ld_byte;
	logic [15:0]   ld_half;
	logic [31:0]   ld_value;

	assign ea = req.base_address + {{20{req.offset[11]}}, req.offset};

	always_comb begin
		unique case (req.mode)
			MODE_LH, MODE_LHU, MODE_SH: misaligned = ea[0];
			MODE_LW, MODE_SW:           misaligned = ea[1:0] != 2'b00;
			MODE_LB, MODE_LBU, MODE_SB: misaligned = 1'b0;
		endcase
	end

	// alignment wins over range
	always_comb begin
		priority if (misaligned) status = ST_MISALIGNED;
		else if ({1'b0, ea} >= MEM_BYTES) status = ST_RANGE;
		else status = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ea_q     <= ea;
			mode_q   <= req.mode;
			data_q   <= req.store_data;
			status_q <= status;
		end
	end

	assign is_store  = (mode_q == MODE_SB) || (mode_q == MODE_SH) || (mode_q == MODE_SW);
	assign access_ok = status_q == ST_OK;

	always_comb begin
		unique case (mode_q)
			MODE_SB: begin
				store_be    = 4'b0001 << ea_q[1:0];
				store_wdata = {4{data_q[7:0]}};
			end
			MODE_SH: begin
				store_be    = ea_q[1] ? 4'b1100 : 4'b0011;
				store_wdata = {2{data_q[15:0]}};
			end
			MODE_SW: begin
				store_be    = 4'b1111;
				store_wdata = data_q;
			end
			MODE_LB, MODE_LH, MODE_LW, MODE_LBU, MODE_LHU: begin
				store_be    = 4'b0000;
				store_wdata = data_q;
			end
		endcase
	end

	always_comb begin
		if (cmd.clear_step) begin
			ram_en    = 1'b1;
			ram_we    = 4'b1111;
			ram_addr  = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_en    = cmd.issue & access_ok;
			ram_we    = (cmd.issue & access_ok & is_store) ? store_be : 4'b0000;
			ram_addr  = ea_q[AW+1:2];
			ram_wdata = store_wdata;
		end
	end

	rlsu_ram #(
		.WIDTH (32),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_comb begin
		unique case (ea_q[1:0])
			2'd0: ld_byte = ram_rdata[7:0];
			2'd1: ld_byte = ram_rdata[15:8];
			2'd2: ld_byte = ram_rdata[23:16];
			2'd3: ld_byte = ram_rdata[31:24];
		endcase
		ld_half = ea_q[1] ? ram_rdata[31:16] : ram_rdata[15:0];
		unique case (mode_q)
			MODE_LB:  ld_value = {{24{ld_byte[7]}}, ld_byte};
			MODE_LBU: ld_value = {24'd0, ld_byte};
			MODE_LH:  ld_value = {{16{ld_half[15]}}, ld_half};
			MODE_LHU: ld_value = {16'd0, ld_half};
			MODE_LW:  ld_value = ram_rdata;
			MODE_SB, MODE_SH, MODE_SW: ld_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_direct || cmd.emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_direct) begin
			rsp_q.load_data <= '0;
			rsp_q.status    <= status_q;
		end else if (cmd.emit_load) begin
			rsp_q.load_data <= ld_value;
			rsp_q.status    <= ST_OK;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign stat.clear_done = clr_cnt_q == LAST_WORD;
	assign stat.load_ok    = access_ok & ~is_store;
	assign stat.out_free   = ~rsp_valid_q | rsp_ready;

endmodule
`default_nettype wire
